// ----- sv/tlv_frame_receiver_unit_assert.svh -----
// assertion macros for the tlv frame receiver checker
`ifndef TLV_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define TLV_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TLVR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TLVR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tlvr_pkg.sv -----
// shared types, codes and helpers of the tlv frame receiver
`timescale 1ns / 1ps
`default_nettype none

package tlvr_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int HDR_IDX_W    = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] MAX_LEN_RESET = 32'd256;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_CMD      = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE     = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO   = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI   = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ_LO   = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST     = HDR_IDX_W'(HEADER_BYTES - 1);

    // request codes from front to back
    localparam logic [1:0] OP_HDR   = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    // result kinds
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_DATA = 3'd1;
    localparam logic [2:0] K_GOOD = 3'd2;
    localparam logic [2:0] K_BAD  = 3'd3;
    localparam logic [2:0] K_LEN  = 3'd4;

    typedef struct packed {
        logic [1:0]           op;
        logic [HDR_IDX_W-1:0] hdr_idx;
        logic                 len_err;
        logic [7:0]           rx_byte;
    } req_t;

    // replace one byte lane of a little-endian word
    function automatic logic [31:0] put_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] res;
        res = word;
        case (lane)
            2'd0:    res[7:0]   = b;
            2'd1:    res[15:8]  = b;
            2'd2:    res[23:16] = b;
            2'd3:    res[31:24] = b;
            default: res = word;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tlvr_front.sv -----
// front end: accepts bytes, tracks frame phase and classifies each request
`timescale 1ns / 1ps
`default_nettype none

module tlvr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wen,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_abort,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output tlvr_pkg::req_t     q_req
);
    import tlvr_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]          remain_reg, remain_next;
    logic [31:0]          len_reg, len_next;
    logic [31:0]          max_len_reg;
    logic                 accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        remain_next     = remain_reg;
        len_next        = len_reg;
        q_req.op        = OP_HDR;
        q_req.hdr_idx   = idx_reg;
        q_req.len_err   = 1'b0;
        q_req.rx_byte   = in_byte;
        if (accept)
        begin
            if (in_abort)
            begin
                q_req.op    = OP_ABORT;
                phase_next  = PH_HEADER;
                idx_next    = '0;
                remain_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        q_req.op    = OP_DATA;
                        remain_next = remain_reg - 32'd1;
                        if (remain_reg == 32'd1)
                            phase_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        q_req.op   = OP_CHECK;
                        phase_next = PH_HEADER;
                        idx_next   = '0;
                    end
                    default:
                    begin
                        // header byte; length lanes mirrored here for the limit check
                        q_req.op = OP_HDR;
                        if (idx_reg >= HDR_LEN_LO && idx_reg <= HDR_LEN_HI)
                            len_next = put_lane(len_reg, 2'(idx_reg - HDR_LEN_LO), in_byte);
                        if (idx_reg == HDR_LAST)
                        begin
                            idx_next = '0;
                            if (len_reg > max_len_reg)
                            begin
                                q_req.len_err = 1'b1;
                                phase_next    = PH_HEADER;
                            end
                            else if (len_reg == 32'd0)
                                phase_next = PH_CHECK;
                            else
                            begin
                                phase_next  = PH_PAYLOAD;
                                remain_next = len_reg;
                            end
                        end
                        else
                            idx_next = idx_reg + 4'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            idx_reg     <= '0;
            remain_reg  <= '0;
            len_reg     <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
            len_reg    <= len_next;
            if (cfg_wen)
                max_len_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tlvr_req_queue.sv -----
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tlvr_req_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tlvr_pkg::req_t     push_req,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output tlvr_pkg::req_t     head_req
);
    import tlvr_pkg::*;

    req_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_req = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tlvr_back.sv -----
// back end: header fields, checksum and the result output register
`timescale 1ns / 1ps
`default_nettype none

module tlvr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  tlvr_pkg::req_t     q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         out_kind,
    output logic [103:0]       out_data
);
    import tlvr_pkg::*;

    logic [7:0]   cmd_reg, cmd_next;
    logic [7:0]   type_reg, type_next;
    logic [31:0]  len_reg, len_next;
    logic [31:0]  seq_reg, seq_next;
    logic [7:0]   sum_reg, sum_next;
    logic         valid_reg;
    logic [2:0]   kind_reg, kind_next;
    logic [103:0] data_reg, data_next;
    logic [7:0]   dbyte, rxsum, csum;
    logic         load;

    assign load      = !valid_reg || out_ready;
    assign q_pop     = load && !q_empty;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        cmd_next  = cmd_reg;
        type_next = type_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        sum_next  = sum_reg;
        kind_next = K_NONE;
        dbyte     = 8'd0;
        rxsum     = 8'd0;
        csum      = sum_reg;
        case (q_head.op)
            OP_DATA:
            begin
                kind_next = K_DATA;
                dbyte     = q_head.rx_byte;
                sum_next  = sum_reg + q_head.rx_byte;
                csum      = sum_next;
            end
            OP_CHECK:
            begin
                kind_next = (q_head.rx_byte == sum_reg) ? K_GOOD : K_BAD;
                rxsum     = q_head.rx_byte;
                sum_next  = 8'd0;
            end
            OP_ABORT:
            begin
                sum_next = 8'd0;
                csum     = 8'd0;
            end
            default:
            begin
                if (q_head.hdr_idx == HDR_CMD)
                    cmd_next = q_head.rx_byte;
                else if (q_head.hdr_idx == HDR_TYPE)
                    type_next = q_head.rx_byte;
                else if (q_head.hdr_idx < HDR_SEQ_LO)
                    len_next = put_lane(len_reg, 2'(q_head.hdr_idx - HDR_LEN_LO),
                                        q_head.rx_byte);
                else
                    seq_next = put_lane(seq_reg, 2'(q_head.hdr_idx - HDR_SEQ_LO),
                                        q_head.rx_byte);
                if (q_head.len_err)
                    kind_next = K_LEN;
            end
        endcase
        data_next = {csum, rxsum, seq_next, len_next, type_next, cmd_next, dbyte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cmd_reg  <= cmd_next;
                type_reg <= type_next;
                len_reg  <= len_next;
                seq_reg  <= seq_next;
                sum_reg  <= sum_next;
            end
            if (load)
                valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tlv_frame_receiver_unit.sv -----
// top level of the tlv frame receiver
//
// byte-serial receiver for tlv frames: 10-byte header (command, type,
// little-endian 32-bit length, little-endian 32-bit sequence), payload
// bytes, then one additive checksum byte.
// input stream: s_tdata carries the received byte, s_tuser is the abort
// flag that restarts the header parse. every accepted request yields
// exactly one result on the output stream: m_tuser is the kind (none,
// payload byte, frame good, checksum bad, length too large), m_tdata the
// payload byte and the saved header fields with both checksums.
// config: cfg_wen/cfg_wdata write the max payload length (256 after reset);
// the user must write it only while the block is idle; it is not enforced.
// a request passes from input acceptance through the queue write, then the
// back end output register, to m_tvalid; throughput is one request per
// cycle while m_tready does not stall the output.
// a 2-entry queue sits between front and back, and the back end has its
// own output register, so input is still taken while a result waits.
// when m_tready is low the output holds and the queue fills; s_tready drops
// once the queue is full.
// reset clears the parse state, saved header fields and the running sum.
`timescale 1ns / 1ps
`default_nettype none

module tlv_frame_receiver_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration write
    input  wire logic          cfg_wen,
    input  wire logic [31:0]   cfg_wdata,
    // input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // rx_byte[7:0]
    input  wire logic          s_tuser,   // operation[0] (abort)
    // output stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [103:0]       m_tdata,   // data_byte[7:0], command[15:8],
                                          // frame_type[23:16], frame_length[55:24],
                                          // sequence_res[87:56],
                                          // received_checksum[95:88],
                                          // computed_checksum[103:96]
    output logic [2:0]         m_tuser    // kind[2:0]
);
    import tlvr_pkg::*;

    // front to queue
    logic q_push;
    logic q_full;
    req_t q_req;

    // queue to back
    logic q_pop;
    logic q_empty;
    req_t q_head;

    // classifies each byte by frame phase and checks the length limit
    tlvr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_abort  (s_tuser),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (q_req)
    );

    // decouples front from back-end stalls
    tlvr_req_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_req),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_req (q_head)
    );

    // keeps header fields and running sum, builds each result
    tlvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/tlvr_checker.sv -----
// port-level checker for the tlv frame receiver and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "tlv_frame_receiver_unit_assert.svh"

module tlvr_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [103:0]  m_tdata,
    input  wire logic [2:0]    m_tuser
);
    import tlvr_pkg::*;

    // stalled result holds
    `TLVR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // frame good means both checksums agree
    `TLVR_ASSERT_IMP(a_good_match, m_tvalid && m_tuser == K_GOOD, m_tdata[95:88] == m_tdata[103:96], "good frame with checksum mismatch")

    // checksum bad means they differ
    `TLVR_ASSERT_IMP(a_bad_differ, m_tvalid && m_tuser == K_BAD, m_tdata[95:88] != m_tdata[103:96], "bad frame with matching checksum")

    // payload byte field is zero except on payload results
    `TLVR_ASSERT_IMP(a_data_zero, m_tvalid && m_tuser != K_DATA, m_tdata[7:0] == 8'd0, "data byte set on non-payload result")

    // input only backs up behind a waiting result
    `TLVR_ASSERT_IMP(a_full_busy, s_tvalid && !s_tready, m_tvalid, "input stalled with no result waiting")

endmodule

bind tlv_frame_receiver_unit tlvr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/tlv_frame_receiver_unit_tb.sv -----
// testbench for the tlv frame receiver: directed and random byte streams checked per result
`timescale 1ns / 1ps

module tlv_frame_receiver_unit_tb;

    import tlvr_pkg::*;

    localparam int NO_KIND          = -1;    // row without a typed-in kind
    localparam int ITEM_GOAL        = 1350;
    localparam int NUM_PHASES       = 7;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_FULL_PAYLOAD = 300;   // longer payloads are cut short by an abort

    // idling per config phase, bit i belongs to phase i
    localparam bit [NUM_PHASES-1:0] SRC_IDLE_PLAN  = 7'b0011101;
    localparam bit [NUM_PHASES-1:0] SINK_IDLE_PLAN = 7'b0110111;

    typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_CHECK} parse_phase_e;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [7:0]  frame_type;
        logic [31:0] frame_length;
        logic [31:0] sequence_res;
        logic [7:0]  rx_csum;
        logic [7:0]  calc_csum;
    } rx_result_t;

    typedef struct {
        bit         abort;
        logic [7:0] rx_byte;
        int         kind;
    } req_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;

    // parser state mirrored by the testbench
    parse_phase_e parse_ph;
    logic [3:0]   hdr_pos;
    logic [7:0]   hdr_command;
    logic [7:0]   hdr_type;
    logic [31:0]  hdr_length;
    logic [31:0]  hdr_sequence;
    logic [31:0]  payload_left;
    logic [7:0]   payload_sum;
    logic [31:0]  cur_max_len;

    rx_result_t   pending_results[$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           src_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;
    bit           long_hold = 1'b0;
    int           stall_left = 0;

    // short directed stream right after reset, limit 256
    req_row_t directed_rows [23] = '{
        // frame: command a5, type 00, length 1, sequence ffffffff
        '{1'b0, 8'hA5, int'(K_NONE)}, '{1'b0, 8'h00, NO_KIND},
        '{1'b0, 8'h01, NO_KIND},      '{1'b0, 8'h00, NO_KIND},
        '{1'b0, 8'h00, NO_KIND},      '{1'b0, 8'h00, NO_KIND},
        '{1'b0, 8'hFF, NO_KIND},      '{1'b0, 8'hFF, NO_KIND},
        '{1'b0, 8'hFF, NO_KIND},      '{1'b0, 8'hFF, int'(K_NONE)},
        '{1'b0, 8'h80, int'(K_DATA)},
        // sum is 80, so 81 is a bad checksum
        '{1'b0, 8'h81, int'(K_BAD)},
        '{1'b1, 8'hFF, int'(K_NONE)},
        // length 257 is one over the limit
        '{1'b0, 8'h00, NO_KIND},      '{1'b0, 8'hFF, NO_KIND},
        '{1'b0, 8'h01, NO_KIND},      '{1'b0, 8'h01, NO_KIND},
        '{1'b0, 8'h00, NO_KIND},      '{1'b0, 8'h00, NO_KIND},
        '{1'b0, 8'h00, NO_KIND},      '{1'b0, 8'h00, NO_KIND},
        '{1'b0, 8'h00, NO_KIND},      '{1'b0, 8'h00, int'(K_LEN)}
    };

    tlv_frame_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_parse();
        parse_ph     = PH_HEADER;
        hdr_pos      = '0;
        payload_left = '0;
        payload_sum  = '0;
    endfunction

    // next parser state and the one result caused by a request
    function automatic rx_result_t parse_rx_byte(input bit abort, input logic [7:0] b);
        rx_result_t r;
        logic [3:0] pos;
        r = '0;
        if (abort)
        begin
            restart_parse();
        end
        else if (parse_ph == PH_PAYLOAD)
        begin
            r.kind       = K_DATA;
            r.data_byte  = b;
            payload_sum  = payload_sum + b;
            payload_left = payload_left - 1;
            if (payload_left == 0)
                parse_ph = PH_CHECK;
        end
        else if (parse_ph == PH_CHECK)
        begin
            r.rx_csum   = b;
            r.calc_csum = payload_sum;
            r.kind      = (b == payload_sum) ? K_GOOD : K_BAD;
            restart_parse();
        end
        else
        begin
            // out-of-range position counts as the last header byte
            pos = (hdr_pos > HDR_LAST) ? HDR_LAST : hdr_pos;
            if (pos == HDR_CMD)
                hdr_command = b;
            else if (pos == HDR_TYPE)
                hdr_type = b;
            else if (pos <= HDR_LEN_HI)
                hdr_length[8*(pos-HDR_LEN_LO) +: 8] = b;
            else
                hdr_sequence[8*(pos-HDR_SEQ_LO) +: 8] = b;
            hdr_pos = pos + 4'd1;
            if (pos == HDR_LAST)
            begin
                restart_parse();
                if (hdr_length > cur_max_len)
                    r.kind = K_LEN;
                else if (hdr_length == 0)
                    parse_ph = PH_CHECK;
                else
                begin
                    parse_ph     = PH_PAYLOAD;
                    payload_left = hdr_length;
                end
            end
        end
        if (r.kind != K_GOOD && r.kind != K_BAD)
            r.calc_csum = payload_sum;
        r.command      = hdr_command;
        r.frame_type   = hdr_type;
        r.frame_length = hdr_length;
        r.sequence_res = hdr_sequence;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input bit abort, input logic [7:0] b, input int typed_kind);
        int gap;
        rx_result_t r;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= abort;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        r = parse_rx_byte(abort, b);
        if (typed_kind != NO_KIND)
            r.kind = typed_kind[2:0];
        pending_results.push_back(r);
        items_sent++;
        @(negedge clk);
    endtask

    // drain, then write the length limit while the block is idle
    task automatic set_max_len(input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen     <= 1'b0;
        cur_max_len = value;
    endtask

    // one frame, mostly well formed; some are cut short, exceed the length limit or carry a bad checksum
    task automatic send_frame();
        logic [31:0] len;
        logic [31:0] seq;
        logic [7:0]  sum;
        logic [7:0]  pb;
        logic [7:0]  hdr [HEADER_BYTES];
        int          pick;
        int          cut;
        int          n;
        int          i;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = $urandom_range(0, 8);
        else if (pick < 72)
            len = $urandom_range(9, MAX_FULL_PAYLOAD);
        else if (pick < 82)
            len = cur_max_len + $urandom_range(0, 1);  // at the limit or one over it
        else
            len = $urandom;
        seq    = $urandom;
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        for (i = 0; i < 4; i++)
        begin
            hdr[2+i] = len[8*i +: 8];
            hdr[6+i] = seq[8*i +: 8];
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES;
        for (i = 0; i < cut; i++)
            send_item(1'b0, hdr[i], NO_KIND);
        if (cut < HEADER_BYTES)
        begin
            send_item(1'b1, 8'($urandom), NO_KIND);
            return;
        end
        if (len > cur_max_len)
            return;
        sum = '0;
        if (len > MAX_FULL_PAYLOAD || $urandom_range(0, 19) == 0)
        begin
            // abort somewhere in the payload or before the checksum
            n = (len > 6) ? $urandom_range(0, 6) : $urandom_range(0, len);
            for (i = 0; i < n; i++)
                send_item(1'b0, 8'($urandom), NO_KIND);
            send_item(1'b1, 8'($urandom), NO_KIND);
            return;
        end
        for (i = 0; i < len; i++)
        begin
            pb  = 8'($urandom);
            sum = sum + pb;
            send_item(1'b0, pb, NO_KIND);
        end
        if ($urandom_range(0, 4) == 0)
            sum = sum + 8'($urandom_range(1, 255));
        send_item(1'b0, sum, NO_KIND);
    endtask

    // a few stray bytes and aborts, then an abort to get back in step
    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++)
            send_item($urandom_range(0, 3) == 0, 8'($urandom), NO_KIND);
        send_item(1'b1, 8'($urandom), NO_KIND);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (long_hold)
        begin
            long_hold  = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
        end
        else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: kind %0h", m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("command", want.command, m_tdata[15:8]);
                check_field("frame_type", want.frame_type, m_tdata[23:16]);
                check_field("frame_length", want.frame_length, m_tdata[55:24]);
                check_field("sequence_res", want.sequence_res, m_tdata[87:56]);
                check_field("received_checksum", want.rx_csum, m_tdata[95:88]);
                check_field("computed_checksum", want.calc_csum, m_tdata[103:96]);
            end
        end
    end

    initial
    begin
        logic [31:0] cfg_plan [NUM_PHASES];
        int i;
        int ph_end;
        cfg_plan[0] = MAX_LEN_RESET;
        cfg_plan[1] = 32'd0;
        cfg_plan[2] = 32'hFFFF_FFFF;
        cfg_plan[3] = 32'd1;
        cfg_plan[4] = $urandom_range(0, MAX_FULL_PAYLOAD);
        cfg_plan[5] = $urandom;
        cfg_plan[6] = 32'd20;

        hdr_command  = '0;
        hdr_type     = '0;
        hdr_length   = '0;
        hdr_sequence = '0;
        cur_max_len  = MAX_LEN_RESET;
        restart_parse();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++)
            send_item(directed_rows[i].abort, directed_rows[i].rx_byte, directed_rows[i].kind);

        for (i = 0; i < NUM_PHASES; i++)
        begin
            set_max_len(cfg_plan[i]);
            src_idle_on  = SRC_IDLE_PLAN[i];
            sink_idle_on = SINK_IDLE_PLAN[i];
            // receiver holds off while the sender streams without gaps
            if (i == 1)
                long_hold = 1'b1;
            // phase ends are fixed points of the whole run, so overshoot does not pile up
            ph_end = ((i + 1) * ITEM_GOAL) / NUM_PHASES;
            do
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_frame();
            end
            while (items_sent < ph_end);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
